>>> rtl/core/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg: shared types and constants of the MIDI scale quantizer
// Register indexes, mode codes, settings and result bundles.
// ----------------------------------------------------------------------------
package msq_pkg;

  localparam int NOTE_W = 7;
  localparam int MASK_W = 12;
  localparam int ROOT_W = 4;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 2;
  localparam int SEMIS  = 12;

  // register indexes on the config port
  localparam logic [IDX_W-1:0] REG_QUANT_MODE = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROOT_KEY   = 2'd1;
  localparam logic [IDX_W-1:0] REG_SCALE_MASK = 2'd2;

  // quantizer modes; the unnamed fourth code passes in-scale notes only
  localparam logic [MODE_W-1:0] QM_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] QM_UP   = 2'd1;
  localparam logic [MODE_W-1:0] QM_DOWN = 2'd2;

  localparam logic [MASK_W-1:0] MASK_RESET = 12'hFFF;

  typedef struct packed {
    logic [MODE_W-1:0] quant_mode;
    logic [ROOT_W-1:0] root_key;
    logic [MASK_W-1:0] scale_mask;
  } settings_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic              dropped;
  } result_t;

endpackage

>>> rtl/core/msq_cfg_regs.sv
// ----------------------------------------------------------------------------
// msq_cfg_regs: configuration register file
// Holds quant_mode, root_key and scale_mask; writes to other indexes vanish.
// ----------------------------------------------------------------------------
module msq_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [msq_pkg::IDX_W-1:0]  cfg_index,
  input  logic [msq_pkg::MASK_W-1:0] cfg_data,
  output msq_pkg::settings_t         settings
);

  always_ff @(posedge clk) begin
    if (rst) begin
      settings.quant_mode <= msq_pkg::QM_OFF;
      settings.root_key   <= '0;
      settings.scale_mask <= msq_pkg::MASK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        msq_pkg::REG_QUANT_MODE: settings.quant_mode <= cfg_data[msq_pkg::MODE_W-1:0];
        msq_pkg::REG_ROOT_KEY:   settings.root_key   <= cfg_data[msq_pkg::ROOT_W-1:0];
        msq_pkg::REG_SCALE_MASK: settings.scale_mask <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/msq_quant.sv
// ----------------------------------------------------------------------------
// msq_quant: combinational scale lookup and nearest-pitch search
// Pitch class via reciprocal multiply, mask window by rotation, then a
// priority search up or down over the eleven neighboring semitones.
// ----------------------------------------------------------------------------
module msq_quant (
  input  logic [msq_pkg::NOTE_W-1:0] note,
  input  msq_pkg::settings_t         settings,
  output msq_pkg::result_t           result
);

  logic [12:0]                 prod;
  logic [3:0]                  quot;
  logic [3:0]                  pc;
  logic [3:0]                  root;
  logic [4:0]                  rel_raw;
  logic [3:0]                  rel;
  logic [2*msq_pkg::MASK_W-1:0] dmask;
  logic [msq_pkg::MASK_W:0]    win;
  logic [3:0]                  up_k;
  logic                        up_hit;
  logic [3:0]                  dn_k;
  logic                        dn_hit;
  logic [7:0]                  up_sum;

  always_comb begin
    // note / 12 == (note * 43) >> 9 for notes 0..127
    prod = 13'(note) * 13'd43;
    quot = prod[12:9];
    pc   = 4'(note - 7'(quot) * 7'd12);
    root = (settings.root_key >= 4'(msq_pkg::SEMIS)) ?
           4'(settings.root_key - 4'(msq_pkg::SEMIS)) : settings.root_key;
    rel_raw = {1'b0, pc} + 5'(msq_pkg::SEMIS) - {1'b0, root};
    rel  = (rel_raw >= 5'(msq_pkg::SEMIS)) ? 4'(rel_raw - 5'(msq_pkg::SEMIS))
                                           : rel_raw[3:0];
    // win[k] tells whether the pitch k semitones above the note is in scale
    dmask = {settings.scale_mask, settings.scale_mask};
    win   = (msq_pkg::MASK_W+1)'(dmask >> rel);

    up_k = '0;
    up_hit = 1'b0;
    dn_k = '0;
    dn_hit = 1'b0;
    for (int k = msq_pkg::SEMIS - 1; k >= 1; k--) begin
      if (win[k]) begin
        up_k = 4'(k);
        up_hit = 1'b1;
      end
      if (win[msq_pkg::SEMIS - k]) begin
        dn_k = 4'(k);
        dn_hit = 1'b1;
      end
    end
    up_sum = {1'b0, note} + {4'd0, up_k};

    result.note    = note;
    result.dropped = 1'b0;
    if (settings.quant_mode != msq_pkg::QM_OFF && !win[0]) begin
      result.dropped = 1'b1;
      case (settings.quant_mode)
        msq_pkg::QM_UP: begin
          if (up_hit && !up_sum[7]) begin
            result.note    = up_sum[6:0];
            result.dropped = 1'b0;
          end
        end
        msq_pkg::QM_DOWN: begin
          if (dn_hit && note >= 7'(dn_k)) begin
            result.note    = note - 7'(dn_k);
            result.dropped = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (result.dropped) begin
      result.note = '0;
    end
  end

endmodule

>>> rtl/core/midi_scale_quantizer.sv
// ----------------------------------------------------------------------------
// midi_scale_quantizer: MIDI note to musical scale quantizer
// Input register, one pass of scale logic, result register.
// ----------------------------------------------------------------------------
// Timing: an accepted note is captured in the input register, and its result
// moves on to the result register, raising out_valid, once that register can load.
// Throughput: one note per cycle while out_ready is high; the input register and the result register
// each hold one transaction, so a waiting result does not block a new note.
// Reset (synchronous, rst high): both stages empty, quant_mode off,
// root_key C, scale_mask all twelve semitones allowed.
module midi_scale_quantizer (
  input  logic                       clk,
  input  logic                       rst,
  // config write channel, always ready
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [msq_pkg::IDX_W-1:0]  cfg_index,
  input  logic [msq_pkg::MASK_W-1:0] cfg_data,
  // note input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [msq_pkg::NOTE_W-1:0] note_in,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [msq_pkg::NOTE_W-1:0] note_out,
  output logic                       dropped
);

  msq_pkg::settings_t         settings;
  msq_pkg::result_t           res_comb;
  logic                       s1_valid;
  logic [msq_pkg::NOTE_W-1:0] s1_note;
  logic                       s2_take;
  logic                       in_fire;

  assign cfg_ready = 1'b1;

  msq_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .settings  (settings)
  );

  // result register can load when empty or drained this cycle
  assign s2_take  = !out_valid || out_ready;
  // input register can load when empty or moving on this cycle
  assign in_ready = !s1_valid || s2_take;
  assign in_fire  = in_valid && in_ready;

  // stage 1: capture the note
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_note <= note_in;
    end
  end

  // scale lookup between the two registers
  msq_quant u_quant (
    .note     (s1_note),
    .settings (settings),
    .result   (res_comb)
  );

  // stage 2: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_take) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid) begin
      note_out <= res_comb.note;
      dropped  <= res_comb.dropped;
    end
  end

`ifndef SYNTH
  // a dropped note always reads as zero
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> note_out == '0)
    else $error("dropped result carries a nonzero note");

  // input only stalls when both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid)
    else $error("input stalled with a free stage");

  // a held stage-1 transaction keeps its note
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_take |=> s1_valid && $stable(s1_note))
    else $error("stage 1 lost or changed a stalled note");

  // both stages are empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
